[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on a rising edge and
// switched off while the asynchronous reset is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/srlc_pkg.sv]
// ---------------------------------------------------------------------------
// srlc_pkg
// widths, bus types, register codes and the power-of-ten table of the
// linear sensor reading conversion
// ---------------------------------------------------------------------------
package srlc_pkg;

	// fraction bits of the fixed-point result
	localparam int FRAC_BITS = 16;

	// field and register widths
	localparam int RAW_W   = 8;
	localparam int M_W     = 10;
	localparam int B_W     = 10;
	localparam int EXP_W   = 4;
	localparam int FIXED_W = 64;
	localparam int WHOLE_W = 32;

	// bus widths
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = FIXED_W + WHOLE_W;

	// exponent arithmetic: signed sums of two exponents, and the scale index
	localparam int EXPK_W = 6;
	localparam int K_W    = 5;

	// datapath widths, from the worst case of |M*x| * 1e8 and |B| * 1e14
	localparam int MX_W   = 18;
	localparam int P1_W   = 27;
	localparam int P2_W   = 47;
	localparam int PROD_W = 45;
	localparam int BT_W   = 57;
	localparam int N_W    = 58;
	localparam int MAG_W  = 57;
	localparam int DEN_W  = 54;
	localparam int NUM_W  = MAG_W + FRAC_BITS;
	localparam int CMP_W  = (NUM_W > FIXED_W + 1) ? NUM_W : FIXED_W + 1;

	// register map, word index
	typedef enum logic [ADDR_W-3:0] {
		REG_SLOPE_M    = 2'd0,
		REG_OFFSET_B   = 2'd1,
		REG_OFFSET_EXP = 2'd2,
		REG_RESULT_EXP = 2'd3
	} reg_idx_t;

	// item entering the divider
	typedef struct packed {
		logic             vld;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} div_op_t;

	// item leaving the divider
	typedef struct packed {
		logic             vld;
		logic             neg;
		logic [NUM_W-1:0] quo;
	} div_res_t;

	// ten to the power e, e from 0 to 16
	function automatic logic [DEN_W-1:0] pow10(input logic [K_W-1:0] e);
		logic [DEN_W-1:0] p;
		case (e)
			5'd0:    p = 54'd1;
			5'd1:    p = 54'd10;
			5'd2:    p = 54'd100;
			5'd3:    p = 54'd1000;
			5'd4:    p = 54'd10000;
			5'd5:    p = 54'd100000;
			5'd6:    p = 54'd1000000;
			5'd7:    p = 54'd10000000;
			5'd8:    p = 54'd100000000;
			5'd9:    p = 54'd1000000000;
			5'd10:   p = 54'd10000000000;
			5'd11:   p = 54'd100000000000;
			5'd12:   p = 54'd1000000000000;
			5'd13:   p = 54'd10000000000000;
			5'd14:   p = 54'd100000000000000;
			5'd15:   p = 54'd1000000000000000;
			5'd16:   p = 54'd10000000000000000;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

[sv/sensor_reading_linear_conversion.sv]
// ---------------------------------------------------------------------------
// sensor_reading_linear_conversion
// converts a raw sensor byte with y = (M*x + B*10^Bexp) * 10^Rexp, exactly,
// into a saturated fixed-point value and a saturated whole value
// ---------------------------------------------------------------------------
//  channel  | role           | beat
//  ---------+----------------+---------------------------------------------
//  s_*      | raw readings   | tdata[7:0] raw_reading
//  m_*      | results        | tdata[63:0] value_fixed, [95:64] value_whole,
//           |                | tuser saturated
//  p*       | register port  | slope_m 0x0, offset_b 0x4, offset_exp 0x8,
//           |                | result_exp 0xC
//
// one beat per cycle in and out while nothing stalls; five front stages,
// 73 divider stages (one quotient bit each, dividend plus fraction bits)
// and a saturation stage before the output register
// reset clears the valid bits and the registers to M=1, B=0, exponents 0
// a stall freezes every stage at once, but only when the last stage holds
// a result that the waiting output register cannot take; bubbles move on
// ---------------------------------------------------------------------------
module sensor_reading_linear_conversion (
	input  logic                               clk,
	input  logic                               arst_n,
	// raw readings
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [srlc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] raw_reading
	// results
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [srlc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [63:0] value_fixed,
	                                                      // [95:64] value_whole
	output logic                               m_tuser,   // [0] saturated
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [srlc_pkg::ADDR_W-1:0]        paddr,
	input  logic [srlc_pkg::DATA_W-1:0]        pwdata,
	output logic [srlc_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import srlc_pkg::*;

	// configuration registers
	logic [M_W-1:0]   slope_m_q;
	logic [B_W-1:0]   offset_b_q;
	logic [EXP_W-1:0] offset_exponent_q;
	logic [EXP_W-1:0] result_exponent_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	// derived scale
	logic signed [EXPK_W-1:0] re_e, be_e, sum_e, lo_e, k_e, e1_e, e2_e;
	logic [K_W-1:0]           cfg_k, cfg_e1, cfg_e2;
	logic [DEN_W-1:0]         den_q;

	// pipeline
	logic                     en;
	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [RAW_W-1:0]         x_s1;
	logic signed [MX_W-1:0]   mx_s2;
	logic [P1_W-1:0]          p1_s2;
	logic [P2_W-1:0]          p2_s2;
	logic [B_W-1:0]           b_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [BT_W-1:0]   bt_s3;
	logic signed [N_W-1:0]    n_s4;
	logic [N_W-1:0]           abs_c;
	logic                     neg_s5;
	logic [MAG_W-1:0]         mag_s5;
	div_op_t                  div_op;
	div_res_t                 div_res;

	// saturation
	logic [CMP_W-1:0]         quo_ext;
	logic [MAG_W-1:0]         q_int;
	logic                     sat_f, sat_w;
	logic [FIXED_W-1:0]       fixed_mag_c;
	logic [WHOLE_W-1:0]       whole_mag_c;
	logic                     neg_s6, sat_s6;
	logic [FIXED_W-1:0]       fixed_mag_s6;
	logic [WHOLE_W-1:0]       whole_mag_s6;

	// output register
	logic                     out_vld_q;
	logic                     ld_out;
	logic [FIXED_W-1:0]       value_fixed_q;
	logic [WHOLE_W-1:0]       value_whole_q;
	logic                     saturated_q;

	// register port: writes in the access phase, reads always ready
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_m_q         <= M_W'(1);
			offset_b_q        <= '0;
			offset_exponent_q <= '0;
			result_exponent_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SLOPE_M:    slope_m_q         <= pwdata[M_W-1:0];
				REG_OFFSET_B:   offset_b_q        <= pwdata[B_W-1:0];
				REG_OFFSET_EXP: offset_exponent_q <= pwdata[EXP_W-1:0];
				REG_RESULT_EXP: result_exponent_q <= pwdata[EXP_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SLOPE_M:    prdata = DATA_W'(slope_m_q);
			REG_OFFSET_B:   prdata = DATA_W'(offset_b_q);
			REG_OFFSET_EXP: prdata = DATA_W'(offset_exponent_q);
			REG_RESULT_EXP: prdata = DATA_W'(result_exponent_q);
		endcase
	end

	// common base: y = n / 10^k, k = -min(0, Rexp, Bexp + Rexp)
	always_comb begin
		re_e  = {{(EXPK_W-EXP_W){result_exponent_q[EXP_W-1]}}, result_exponent_q};
		be_e  = {{(EXPK_W-EXP_W){offset_exponent_q[EXP_W-1]}}, offset_exponent_q};
		sum_e = be_e + re_e;
		lo_e  = '0;
		if (re_e < lo_e) begin
			lo_e = re_e;
		end
		if (sum_e < lo_e) begin
			lo_e = sum_e;
		end
		k_e   = -lo_e;
		e1_e  = re_e + k_e;
		e2_e  = sum_e + k_e;
	end

	assign cfg_k  = k_e[K_W-1:0];
	assign cfg_e1 = e1_e[K_W-1:0];
	assign cfg_e2 = e2_e[K_W-1:0];

	// divisor follows the registers; the user must change them only while no item is in flight (not enforced)
	always_ff @(posedge clk) begin
		den_q <= pow10(cfg_k);
	end

	// everything moves unless a finished result has nowhere to go
	assign en       = !vld_s6 || !out_vld_q || m_tready;
	assign s_tready = en;
	assign ld_out   = vld_s6 && (!out_vld_q || m_tready);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= div_res.vld;
		end
	end

	// front stages: input, slope product and powers, scaled terms, sum, magnitude
	assign abs_c = n_s4[N_W-1] ? (N_W'(0) - n_s4) : n_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= s_tdata[RAW_W-1:0];
			mx_s2   <= $signed({{(MX_W-M_W){slope_m_q[M_W-1]}}, slope_m_q})
			         * $signed({{(MX_W-RAW_W){1'b0}}, x_s1});
			p1_s2   <= P1_W'(pow10(cfg_e1));
			p2_s2   <= P2_W'(pow10(cfg_e2));
			b_s2    <= offset_b_q;
			prod_s3 <= $signed({{(PROD_W-MX_W){mx_s2[MX_W-1]}}, mx_s2})
			         * $signed({{(PROD_W-P1_W){1'b0}}, p1_s2});
			bt_s3   <= $signed({{(BT_W-B_W){b_s2[B_W-1]}}, b_s2})
			         * $signed({{(BT_W-P2_W){1'b0}}, p2_s2});
			n_s4    <= $signed({{(N_W-PROD_W){prod_s3[PROD_W-1]}}, prod_s3})
			         + $signed({{(N_W-BT_W){bt_s3[BT_W-1]}}, bt_s3});
			neg_s5  <= n_s4[N_W-1];
			mag_s5  <= abs_c[MAG_W-1:0];
		end
	end

	// long division of mag * 2^FRAC_BITS by 10^k
	assign div_op.vld = vld_s5;
	assign div_op.neg = neg_s5;
	assign div_op.mag = mag_s5;

	srlc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.den     (den_q),
		.operand (div_op),
		.result  (div_res)
	);

	// clip both magnitudes to the range of their sign
	always_comb begin
		quo_ext = CMP_W'(div_res.quo);
		q_int   = div_res.quo[NUM_W-1:FRAC_BITS];
		sat_f   = (|quo_ext[CMP_W-1:FIXED_W])
		       || (quo_ext[FIXED_W-1] && (!div_res.neg || (|quo_ext[FIXED_W-2:0])));
		sat_w   = (|q_int[MAG_W-1:WHOLE_W])
		       || (q_int[WHOLE_W-1] && (!div_res.neg || (|q_int[WHOLE_W-2:0])));
		if (sat_f) begin
			fixed_mag_c = div_res.neg ? {1'b1, {(FIXED_W-1){1'b0}}}
			                          : {1'b0, {(FIXED_W-1){1'b1}}};
		end else begin
			fixed_mag_c = quo_ext[FIXED_W-1:0];
		end
		if (sat_w) begin
			whole_mag_c = div_res.neg ? {1'b1, {(WHOLE_W-1){1'b0}}}
			                          : {1'b0, {(WHOLE_W-1){1'b1}}};
		end else begin
			whole_mag_c = q_int[WHOLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6       <= div_res.neg;
			sat_s6       <= sat_f || sat_w;
			fixed_mag_s6 <= fixed_mag_c;
			whole_mag_s6 <= whole_mag_c;
		end
	end

	// output register: apply the sign on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			value_fixed_q <= neg_s6 ? (FIXED_W'(0) - fixed_mag_s6) : fixed_mag_s6;
			value_whole_q <= neg_s6 ? (WHOLE_W'(0) - whole_mag_s6) : whole_mag_s6;
			saturated_q   <= sat_s6;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {value_whole_q, value_fixed_q};
	assign m_tuser  = saturated_q;

endmodule

[sv/srlc_div.sv]
// ---------------------------------------------------------------------------
// srlc_div
// pipelined restoring divider: one quotient bit per stage, the dividend
// shifted up and the quotient shifted in through the same register
// ---------------------------------------------------------------------------
module srlc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [srlc_pkg::DEN_W-1:0]   den,
	input  srlc_pkg::div_op_t            operand,
	output srlc_pkg::div_res_t           result
);
	import srlc_pkg::*;

	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] nq_s  [NUM_W];
	logic             neg_s [NUM_W];
	logic             vld_s [NUM_W];

	for (genvar j = 0; j < NUM_W; j++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] nq_in;
		logic             neg_in;
		logic             vld_in;
		logic [DEN_W:0]   trial;
		logic             fit;

		// stage source: the operand, or the stage before
		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = {operand.mag, {FRAC_BITS{1'b0}}};
			assign neg_in = operand.neg;
			assign vld_in = operand.vld;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign nq_in  = nq_s[j-1];
			assign neg_in = neg_s[j-1];
			assign vld_in = vld_s[j-1];
		end

		// bring down the next dividend bit and try the subtraction
		assign trial = {rem_in, nq_in[NUM_W-1]};
		assign fit   = (trial >= {1'b0, den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= fit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
				nq_s[j]  <= {nq_in[NUM_W-2:0], fit};
				neg_s[j] <= neg_in;
			end
		end
	end

	// last stage holds the whole quotient
	assign result.vld = vld_s[NUM_W-1];
	assign result.neg = neg_s[NUM_W-1];
	assign result.quo = nq_s[NUM_W-1];

endmodule

[sv/srlc_checker.sv]
// ---------------------------------------------------------------------------
// srlc_checker
// port-level checks of the linear sensor reading conversion, bound to the
// top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srlc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [srlc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [63:0] value_fixed,
	                                                     // [95:64] value_whole
	input logic                               m_tuser    // [0] saturated
);
	import srlc_pkg::*;

	logic [FIXED_W-1:0] fixed_v;
	logic [WHOLE_W-1:0] whole_v;
	logic [FIXED_W-1:0] fixed_abs;
	logic [FIXED_W-1:0] fixed_int;
	logic [WHOLE_W-1:0] whole_exp;
	logic               at_limit;
	logic               stalled;
	logic               out_idle;
	logic               plain_beat;
	logic               clip_beat;
	logic               whole_ok;

	// whole part implied by the fixed-point value, truncated toward zero
	always_comb begin
		fixed_v    = m_tdata[FIXED_W-1:0];
		whole_v    = m_tdata[OUT_TDATA_W-1:FIXED_W];
		fixed_abs  = fixed_v[FIXED_W-1] ? (FIXED_W'(0) - fixed_v) : fixed_v;
		fixed_int  = fixed_abs >> FRAC_BITS;
		whole_exp  = fixed_v[FIXED_W-1] ? (WHOLE_W'(0) - fixed_int[WHOLE_W-1:0])
		                                : fixed_int[WHOLE_W-1:0];
		at_limit   = (fixed_v == {1'b1, {(FIXED_W-1){1'b0}}})
		          || (fixed_v == {1'b0, {(FIXED_W-1){1'b1}}})
		          || (whole_v == {1'b1, {(WHOLE_W-1){1'b0}}})
		          || (whole_v == {1'b0, {(WHOLE_W-1){1'b1}}});
		stalled    = m_tvalid && !m_tready;
		out_idle   = !m_tvalid;
		plain_beat = m_tvalid && !m_tuser;
		clip_beat  = m_tvalid && m_tuser;
		whole_ok   = (whole_v == whole_exp);
	end

	// a waiting result beat holds still
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_tvalid && $stable({m_tuser, m_tdata}), "beat moved in a stall")

	// an empty output register never holds back the input
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, out_idle, s_tready, "input held while empty")

	// unclipped results agree with each other
	`ASSERT_IMPLIES(a_whole_matches_fixed, clk, arst_n, plain_beat, whole_ok, "whole and fixed differ")

	// a clipped result shows a limit in one of its forms
	`ASSERT_IMPLIES(a_sat_at_limit, clk, arst_n, clip_beat, at_limit, "clip flag without a limit")

endmodule

bind sensor_reading_linear_conversion srlc_checker u_srlc_checker (.*);
